>>> rtl/core/hpdtmc_pkg.sv
package hpdtmc_pkg;

    typedef logic signed [8:0]  cmd_t;
    typedef logic signed [33:0] acc_t;

    typedef enum logic [1:0]
    {
        REG_TARGET_HEADING = 2'd0,
        REG_ARM_ANGLE      = 2'd1,
        REG_GAIN_P         = 2'd2,
        REG_GAIN_D         = 2'd3
    } reg_idx_t;

    localparam logic [5:0] MODE_ARM_EXTEND  = 6'd12;
    localparam logic [5:0] MODE_GRIP        = 6'd13;
    localparam logic [5:0] MODE_ARM_RETRACT = 6'd14;
    localparam logic [5:0] MODE_ARM_STOW    = 6'd15;
    localparam logic [5:0] MODE_HOLD_A      = 6'd20;
    localparam logic [5:0] MODE_HOLD_B      = 6'd21;
    localparam logic [5:0] MODE_HOLD_FWD    = 6'd22;
    localparam logic [5:0] MODE_FULL        = 6'd30;

    localparam cmd_t CMD_MAX        = 9'sd255;
    localparam cmd_t CMD_MIN        = -9'sd255;
    localparam cmd_t ARM_LIN_SPEED  = 9'sd100;
    localparam cmd_t ARM_STOW_SPEED = 9'sd80;
    localparam cmd_t GRIPPER_SPEED  = 9'sd70;

    localparam logic signed [14:0] DEADBAND = 15'sd16;
    localparam logic signed [14:0] ERR_OK   = 15'sd240;

    // floor(x/12) as (x*2731)>>15, exact for x up to 3360
    localparam logic [23:0] RECIP_12 = 24'd2731;
    localparam int          RECIP_SH = 15;

    localparam int GAIN_FRAC = 12;

    function automatic cmd_t sat_cmd(input acc_t v);
        cmd_t r;
        if (v > 34'sd255)
            r = CMD_MAX;
        else if (v < -34'sd255)
            r = CMD_MIN;
        else
            r = v[8:0];
        return r;
    endfunction

    // trunc((acc*4096 + prod)/4096), rounding toward zero
    function automatic acc_t add_scaled(input acc_t acc, input acc_t prod);
        acc_t s;
        s = (acc <<< GAIN_FRAC) + prod;
        if (s < 0)
            s = s + 34'sd4095;
        return s >>> GAIN_FRAC;
    endfunction

endpackage

>>> rtl/core/heading_pd_thrust_mode_controller.sv
// pipeline: two register stages (input register, result register); an accepted item
// waits in the input register until the result register is free, then raises m_tvalid
// throughput: one item per cycle unless m_tready stalls; while a result waits, the input
// stage takes one more item and then holds
// the per-item path is the pd step: two 15x17 multiplies feeding a chain of scaled adds
// reset: rst_n asynchronous active low; valids, previous heading and all
// configuration registers clear to zero
module heading_pd_thrust_mode_controller
    import hpdtmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode_code[5:0], heading[19:6], zero[23:20]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // thrust_right[8:0], thrust_left[17:9],
                                   // base_stepper_cmd[26:18], arm_motor_cmd[35:27],
                                   // gripper_cmd[44:36], zero[47:45]
);

    logic signed [13:0] target_heading_reg;
    logic signed [13:0] arm_angle_reg;
    logic [15:0]        gain_p_reg;
    logic [15:0]        gain_d_reg;
    logic signed [13:0] prev_heading_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [5:0]         mode_reg;
    logic signed [13:0] heading_reg;
    logic signed [13:0] prev_snap_reg;

    cmd_t right_reg, right_next;
    cmd_t left_reg, left_next;
    cmd_t base_reg, base_next;
    cmd_t arm_reg, arm_next;
    cmd_t grip_reg, grip_next;

    logic     cfg_write;
    reg_idx_t cfg_idx;
    logic     in_xfer;
    logic     advance;

    logic signed [14:0] err;
    logic signed [14:0] dlt;
    logic signed [31:0] prod_p;
    logic signed [31:0] prod_d;
    logic signed [14:0] fwd_span;
    logic [11:0]        fwd_num;
    logic [23:0]        fwd_scaled;
    logic [8:0]         fwd;
    logic               outside_deadband;
    logic               near_target;
    acc_t               r_acc, l_acc;
    logic signed [15:0] base_x3;
    logic signed [15:0] base_q;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_heading_reg <= '0;
            arm_angle_reg      <= '0;
            gain_p_reg         <= '0;
            gain_d_reg         <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_TARGET_HEADING: target_heading_reg <= pwdata[13:0];
                REG_ARM_ANGLE:      arm_angle_reg      <= pwdata[13:0];
                REG_GAIN_P:         gain_p_reg         <= pwdata[15:0];
                REG_GAIN_D:         gain_d_reg         <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TARGET_HEADING: prdata = {{18{target_heading_reg[13]}}, target_heading_reg};
            REG_ARM_ANGLE:      prdata = {{18{arm_angle_reg[13]}}, arm_angle_reg};
            REG_GAIN_P:         prdata = {16'd0, gain_p_reg};
            REG_GAIN_D:         prdata = {16'd0, gain_d_reg};
            default:            prdata = '0;
        endcase
    end

    // pipeline control
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            prev_heading_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_xfer)
                prev_heading_reg <= s_tdata[19:6];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg      <= s_tdata[5:0];
            heading_reg   <= s_tdata[19:6];
            prev_snap_reg <= prev_heading_reg;
        end
        if (advance && s1_valid_reg)
        begin
            right_reg <= right_next;
            left_reg  <= left_next;
            base_reg  <= base_next;
            arm_reg   <= arm_next;
            grip_reg  <= grip_next;
        end
    end

    // heading error, derivative and gain products
    always_comb
    begin
        err    = 15'(target_heading_reg) - 15'(heading_reg);
        dlt    = 15'(heading_reg) - 15'(prev_snap_reg);
        prod_p = err * $signed({1'b0, gain_p_reg});
        prod_d = dlt * $signed({1'b0, gain_d_reg});

        outside_deadband = (err >= DEADBAND) || (err <= -DEADBAND);
        near_target      = (err <= ERR_OK) && (err >= -ERR_OK);

        // forward speed 7*(240-e)/12, span is 0..480 when near target
        fwd_span   = ERR_OK - err;
        fwd_num    = 12'(fwd_span[8:0]) * 12'd7;
        fwd_scaled = 24'(fwd_num) * RECIP_12;
        fwd        = fwd_scaled[RECIP_SH +: 9];

        // arm angle in degrees times 1.5, truncated toward zero
        base_x3 = 16'(arm_angle_reg) * 16'sd3;
        base_q  = (base_x3 < 0) ? ((base_x3 + 16'sd31) >>> 5) : (base_x3 >>> 5);
    end

    always_comb
    begin
        r_acc     = '0;
        l_acc     = '0;
        right_next = '0;
        left_next  = '0;
        base_next  = '0;
        arm_next   = '0;
        grip_next  = '0;
        case (mode_reg)
            MODE_ARM_EXTEND:
            begin
                base_next = sat_cmd(34'(base_q));
                arm_next  = ARM_LIN_SPEED;
            end
            MODE_GRIP:
                grip_next = GRIPPER_SPEED;
            MODE_ARM_RETRACT:
            begin
                base_next = sat_cmd(34'(base_q));
                arm_next  = -ARM_LIN_SPEED;
            end
            MODE_ARM_STOW:
                base_next = ARM_STOW_SPEED;
            MODE_HOLD_A, MODE_HOLD_B, MODE_HOLD_FWD:
            begin
                if (mode_reg == MODE_HOLD_FWD && near_target)
                begin
                    r_acc = 34'($signed({1'b0, fwd}));
                    l_acc = r_acc;
                end
                if (outside_deadband)
                begin
                    r_acc = add_scaled(r_acc, -34'(prod_p));
                    l_acc = add_scaled(l_acc, 34'(prod_p));
                    r_acc = add_scaled(r_acc, 34'(prod_d));
                    l_acc = add_scaled(l_acc, -34'(prod_d));
                end
                right_next = sat_cmd(r_acc);
                left_next  = sat_cmd(l_acc);
            end
            MODE_FULL:
            begin
                right_next = CMD_MAX;
                left_next  = CMD_MAX;
            end
            default:
                ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, grip_reg, arm_reg, base_reg, left_reg, right_reg};

    // an accepted item always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("accepted item missing from input stage");

    // previous heading follows every accepted item, whatever the mode
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> prev_heading_reg == $past(s_tdata[19:6]))
        else $error("previous heading not updated");

    // saturation never lets the thruster commands reach -256
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[8:0] != 9'h100) && (m_tdata[17:9] != 9'h100))
        else $error("thrust command outside saturation range");

endmodule

>>> verif/heading_pd_thrust_mode_controller_tb.sv
`timescale 1ns / 1ps

module heading_pd_thrust_mode_controller_tb;
    import hpdtmc_pkg::*;

    localparam longint FWD_SPEED     = 140;
    localparam longint GAIN_ONE      = 4096;
    localparam longint HEADING_LIM   = 5760;
    localparam longint GAIN_TOP      = 65535;
    localparam int     DRAIN_CYCLES  = 6;
    localparam int     PHASE_ITEMS   = 228;
    localparam int     CYCLE_LIMIT   = 400000;

    typedef struct packed
    {
        logic [13:0] heading;
        logic [5:0]  mode;
    } sensor_item_t;

    typedef struct packed
    {
        cmd_t grip_cmd;
        cmd_t arm_cmd;
        cmd_t base_cmd;
        cmd_t thrust_l;
        cmd_t thrust_r;
    } motor_cmds_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b1;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    sensor_item_t sensor_q[$];
    motor_cmds_t  motor_cmd_q[$];

    // controller copy of the configuration and the derivative state
    longint tgt_heading = 0;
    longint arm_setting = 0;
    longint gain_p = 0;
    longint gain_d = 0;
    longint prev_heading = 0;
    longint last_hd = 0;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        s_taken = 1'b0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    string fld_name[5] = '{"thrust_right", "thrust_left", "base_stepper_cmd",
                           "arm_motor_cmd", "gripper_cmd"};

    heading_pd_thrust_mode_controller dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pd step with truncation toward zero at every update
    function automatic longint scaled_add(input longint acc, input longint prod);
        return (acc * GAIN_ONE + prod) / GAIN_ONE;
    endfunction

    function automatic cmd_t clamp_cmd(input longint v);
        if (v > longint'(CMD_MAX))
            return CMD_MAX;
        if (v < longint'(CMD_MIN))
            return CMD_MIN;
        return cmd_t'(v[8:0]);
    endfunction

    function automatic motor_cmds_t predict_motor_cmds(input sensor_item_t it);
        motor_cmds_t c;
        longint hd, e, d, ae, r, l, base, arm, grip;
        hd = longint'($signed(it.heading));
        e = tgt_heading - hd;
        d = hd - prev_heading;
        ae = (e < 0) ? -e : e;
        r = 0;
        l = 0;
        base = 0;
        arm = 0;
        grip = 0;
        case (it.mode)
            MODE_ARM_EXTEND:
            begin
                base = arm_setting * 3 / 32;
                arm = longint'(ARM_LIN_SPEED);
            end
            MODE_GRIP:
                grip = longint'(GRIPPER_SPEED);
            MODE_ARM_RETRACT:
            begin
                base = arm_setting * 3 / 32;
                arm = -longint'(ARM_LIN_SPEED);
            end
            MODE_ARM_STOW:
                base = longint'(ARM_STOW_SPEED);
            MODE_HOLD_A, MODE_HOLD_B, MODE_HOLD_FWD:
            begin
                if (it.mode == MODE_HOLD_FWD && ae <= longint'(ERR_OK))
                begin
                    r = (FWD_SPEED * (longint'(ERR_OK) - e)) / longint'(ERR_OK);
                    l = r;
                end
                if (ae >= longint'(DEADBAND))
                begin
                    r = scaled_add(r, -(e * gain_p));
                    l = scaled_add(l, e * gain_p);
                    r = scaled_add(r, d * gain_d);
                    l = scaled_add(l, -(d * gain_d));
                end
            end
            MODE_FULL:
            begin
                r = longint'(CMD_MAX);
                l = longint'(CMD_MAX);
            end
            default:
                ;
        endcase
        prev_heading = hd;
        c.thrust_r = clamp_cmd(r);
        c.thrust_l = clamp_cmd(l);
        c.base_cmd = clamp_cmd(base);
        c.arm_cmd = clamp_cmd(arm);
        c.grip_cmd = clamp_cmd(grip);
        return c;
    endfunction

    function automatic sensor_item_t mk_item(input logic [5:0] m, input longint h);
        sensor_item_t it;
        it.mode = m;
        it.heading = h[13:0];
        return it;
    endfunction

    // mostly heading modes, near target, drifting or anywhere, with arm and other codes
    function automatic sensor_item_t rand_item();
        logic [5:0] m;
        longint     h;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            m = MODE_HOLD_A + 6'($urandom_range(0, 2));
        else if (pick < 80)
            m = MODE_ARM_EXTEND + 6'($urandom_range(0, 3));
        else if (pick < 85)
            m = MODE_FULL;
        else
            m = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 35)
            h = tgt_heading + longint'($urandom_range(0, 600)) - 300;
        else if (pick < 60)
            h = last_hd + longint'($urandom_range(0, 200)) - 100;
        else
            h = longint'($urandom_range(0, 2 * HEADING_LIM)) - HEADING_LIM;
        if (h > HEADING_LIM)
            h = HEADING_LIM;
        if (h < -HEADING_LIM)
            h = -HEADING_LIM;
        last_hd = h;
        return mk_item(m, h);
    endfunction

    task automatic write_reg(input reg_idx_t idx, input longint val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val[31:0];
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TARGET_HEADING: tgt_heading = val;
            REG_ARM_ANGLE:      arm_setting = val;
            REG_GAIN_P:         gain_p = val;
            REG_GAIN_D:         gain_d = val;
            default:            ;
        endcase
    endtask

    task automatic set_config(input longint t, input longint a, input longint kp,
                              input longint kd);
        write_reg(REG_TARGET_HEADING, t);
        write_reg(REG_ARM_ANGLE, a);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_D, kd);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (sensor_q.size() != 0 || s_tvalid || motor_cmd_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // driver: new item only once the previous transfer has happened
    always @(negedge clk)
    begin
        if (!s_tvalid || s_taken)
        begin
            if (rst_n && sensor_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tdata <= {4'b0000, sensor_q.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: check the oldest expectation, then predict for the input transfer
    always @(posedge clk)
    begin
        motor_cmds_t want;
        logic [44:0] exp_bits;
        logic [44:0] act_bits;
        s_taken <= s_tvalid && s_tready;
        if (m_tvalid && m_tready)
        begin
            if (motor_cmd_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = motor_cmd_q.pop_front();
                exp_bits = want;
                act_bits = m_tdata[44:0];
                for (int k = 0; k < 5; k++)
                begin
                    if (act_bits[9*k +: 9] !== exp_bits[9*k +: 9])
                    begin
                        $display("%0t: %s expected %0d, got %0d", $time, fld_name[k],
                                 $signed(exp_bits[9*k +: 9]), $signed(act_bits[9*k +: 9]));
                        mismatches++;
                    end
                end
            end
        end
        if (s_tvalid && s_tready)
            motor_cmd_q.push_back(predict_motor_cmds(s_tdata[19:0]));
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int p;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: target 10 degrees so both error signs sit inside the field range
        set_config(160, -1000, 512, 300);
        sensor_q.push_back(mk_item('0, 0));
        sensor_q.push_back(mk_item('1, -HEADING_LIM));
        sensor_q.push_back(mk_item(MODE_ARM_EXTEND, HEADING_LIM));
        sensor_q.push_back(mk_item(MODE_GRIP, 0));
        sensor_q.push_back(mk_item(MODE_ARM_RETRACT, -1));
        sensor_q.push_back(mk_item(MODE_ARM_STOW, 8191 - 8192 + 1));
        sensor_q.push_back(mk_item(MODE_FULL, 100));
        sensor_q.push_back(mk_item(MODE_HOLD_A, 160));
        // deadband edges
        sensor_q.push_back(mk_item(MODE_HOLD_A, 145));
        sensor_q.push_back(mk_item(MODE_HOLD_B, 144));
        sensor_q.push_back(mk_item(MODE_HOLD_B, 176));
        // forward speed window edges
        sensor_q.push_back(mk_item(MODE_HOLD_FWD, 160 - 240));
        sensor_q.push_back(mk_item(MODE_HOLD_FWD, 160 + 240));
        sensor_q.push_back(mk_item(MODE_HOLD_FWD, 160 - 241));
        sensor_q.push_back(mk_item(MODE_HOLD_FWD, 160));
        sensor_q.push_back(mk_item(MODE_HOLD_FWD, 150));
        // saturation and large derivative swing
        sensor_q.push_back(mk_item(MODE_HOLD_A, -HEADING_LIM));
        sensor_q.push_back(mk_item(MODE_HOLD_A, HEADING_LIM));
        sensor_q.push_back(mk_item(MODE_HOLD_B, -HEADING_LIM));
        // idle codes next to the used ones
        sensor_q.push_back(mk_item(MODE_ARM_EXTEND - 6'd1, 40));
        sensor_q.push_back(mk_item(MODE_ARM_STOW + 6'd1, -40));
        sensor_q.push_back(mk_item(MODE_HOLD_A - 6'd1, 300));
        sensor_q.push_back(mk_item(MODE_HOLD_FWD + 6'd1, -300));
        sensor_q.push_back(mk_item(MODE_FULL - 6'd1, 0));
        sensor_q.push_back(mk_item(MODE_FULL + 6'd1, 0));
        wait_drained();

        for (p = 1; p <= 8; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (p == 1)
                set_config(HEADING_LIM, HEADING_LIM, GAIN_TOP, GAIN_TOP);
            else if (p == 2)
                set_config(-HEADING_LIM, -HEADING_LIM, 0, 0);
            else if (p == 3)
                set_config(0, 0, 256, 0);
            else
                set_config(longint'($urandom_range(0, 2 * HEADING_LIM)) - HEADING_LIM,
                           longint'($urandom_range(0, 2 * HEADING_LIM)) - HEADING_LIM,
                           ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, 65535))
                                                       : longint'($urandom_range(0, 2048)),
                           ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, 65535))
                                                       : longint'($urandom_range(0, 2048)));
            repeat (PHASE_ITEMS) sensor_q.push_back(rand_item());
            wait_drained();
        end

        if (mismatches == 0 && motor_cmd_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/hpdtmc_pkg.sv
rtl/core/heading_pd_thrust_mode_controller.sv
verif/heading_pd_thrust_mode_controller_tb.sv
